@@ sv/sha512_message_digest_top_macros.svh @@
// assertion helpers
`ifndef SHA512_MESSAGE_DIGEST_TOP_MACROS_SVH
`define SHA512_MESSAGE_DIGEST_TOP_MACROS_SVH
`define SHA_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error("label");
`define SHA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("label");
`endif

@@ sv/sha_pkg.sv @@
`default_nettype none
package sha_pkg;
	localparam int Rounds = 80;
	localparam logic [63:0] IV [8] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
		64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F, 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};
	localparam logic [63:0] K [80] = '{
		64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
		64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
		64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
		64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
		64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
		64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
		64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
		64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
		64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
		64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
		64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
		64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
		64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
		64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
		64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
		64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
		64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
		64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
		64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
		64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817};
	// queue entry: one full block plus whether it closes the message
	typedef struct packed {
		logic [1023:0] block;
		logic          last;
	} sha_blk_t;
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} sha_in_t;
	typedef struct packed {
		logic [63:0] digest_word;
		logic [2:0]  word_number;
		logic        final_word;
	} sha_out_t;
	function automatic logic [63:0] ror(input logic [63:0] x, input int n);
		ror = (x >> n) | (x << (64 - n));
	endfunction
endpackage
`default_nettype wire

@@ sv/sha_if.sv @@
`default_nettype none
interface sha_if #(parameter int W = 10) (input wire logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ sv/sha_front.sv @@
`default_nettype none
// packs bytes, pads, and pushes full blocks into the queue
module sha_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire sha_pkg::sha_in_t  in_item,
	output logic                   blk_valid,
	input  wire logic              blk_ready,
	output sha_pkg::sha_blk_t      blk
);
	import sha_pkg::*;
	localparam logic [1:0] F_IN = 2'd0, F_PAD = 2'd1, F_LEN = 2'd2;
	logic [1:0]    state_q;
	logic [1023:0] buf_q;
	logic [6:0]    pos_q;
	logic [60:0]   len_q;
	logic          pend_q;
	logic [1023:0] put;
	logic [6:0]    npos;
	logic [1023:0] padded;
	logic [1023:0] mask;

	assign in_ready  = (state_q == F_IN) && !pend_q;
	assign blk_valid = pend_q;

	always_comb begin
		put = buf_q;
		put[(7'd127 - pos_q) * 8 +: 8] = in_item.data_byte;
		npos = pos_q + 7'd1;
		mask = {1024{1'b1}} << ((8'd128 - {1'b0, pos_q}) * 8);
		padded = (buf_q & mask) | ({1016'b0, 8'h80} << ((7'd127 - pos_q) * 8));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IN;
			pos_q <= '0;
			len_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (pend_q && blk_ready)
				pend_q <= 1'b0;
			case (state_q)
				F_IN: begin
					if (in_valid && in_ready) begin
						if (in_item.byte_present) begin
							buf_q <= put;
							pos_q <= npos;
							len_q <= len_q + 61'd1;
							if (npos == 7'd0) begin
								blk.block <= put;
								blk.last <= 1'b0;
								pend_q <= 1'b1;
							end
						end
						if (in_item.end_of_message)
							state_q <= F_PAD;
					end
				end
				F_PAD: begin
					if (!pend_q) begin
						if (pos_q >= 7'd112) begin
							blk.block <= padded;
							blk.last <= 1'b0;
							pend_q <= 1'b1;
							buf_q <= '0;
							state_q <= F_LEN;
						end else begin
							blk.block <= {padded[1023:128], 64'd0, len_q, 3'b000};
							blk.last <= 1'b1;
							pend_q <= 1'b1;
							pos_q <= '0;
							len_q <= '0;
							state_q <= F_IN;
						end
					end
				end
				F_LEN: begin
					if (!pend_q) begin
						blk.block <= {buf_q[1023:128], 64'd0, len_q, 3'b000};
						blk.last <= 1'b1;
						pend_q <= 1'b1;
						pos_q <= '0;
						len_q <= '0;
						state_q <= F_IN;
					end
				end
				default: state_q <= F_IN;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ sv/sha_fifo.sv @@
`default_nettype none
// two-entry block queue
module sha_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_valid,
	output logic                   wr_ready,
	input  wire sha_pkg::sha_blk_t wr_data,
	output logic                   rd_valid,
	input  wire logic              rd_ready,
	output sha_pkg::sha_blk_t      rd_data
);
	import sha_pkg::*;
	sha_blk_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= ~wp_q;
			if (rd)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule
`default_nettype wire

@@ sv/sha_core.sv @@
`default_nettype none
// 80-round compression, one round per cycle, then digest output after a message's last block
module sha_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              blk_valid,
	output logic                   blk_ready,
	input  wire sha_pkg::sha_blk_t blk,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sha_pkg::sha_out_t      out_item
);
	import sha_pkg::*;
	localparam logic [1:0] C_IDLE = 2'd0, C_RUN = 2'd1, C_ADD = 2'd2, C_OUT = 2'd3;
	logic [1:0]  state_q;
	logic [63:0] hv_q [8];
	logic [63:0] wv_q [8];
	logic [63:0] w_q [16];
	logic [6:0]  rnd_q;
	logic [2:0]  widx_q;
	logic        last_q;
	logic [63:0] x15, x2, wnew, wr, t1, t2, e, a;

	assign blk_ready = (state_q == C_IDLE);
	assign out_valid = (state_q == C_OUT);
	assign out_item.digest_word = hv_q[widx_q];
	assign out_item.word_number = widx_q;
	assign out_item.final_word  = (widx_q == 3'd7);

	always_comb begin
		x15 = w_q[1];
		x2 = w_q[14];
		wnew = w_q[0] + (ror(x15, 1) ^ ror(x15, 8) ^ (x15 >> 7)) + w_q[9]
			+ (ror(x2, 19) ^ ror(x2, 61) ^ (x2 >> 6));
		wr = w_q[0];
		e = wv_q[4];
		a = wv_q[0];
		t1 = wv_q[7] + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41)) + ((e & wv_q[5]) ^ (~e & wv_q[6]))
			+ K[rnd_q] + wr;
		t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39))
			+ ((a & wv_q[1]) ^ (a & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (blk_valid) begin
					for (int i = 0; i < 16; i++)
						w_q[i] <= blk.block[(15 - i) * 64 +: 64];
					for (int i = 0; i < 8; i++)
						wv_q[i] <= hv_q[i];
				end
			end
			C_RUN: begin
				for (int i = 0; i < 15; i++)
					w_q[i] <= w_q[i + 1];
				w_q[15] <= wnew;
				wv_q[7] <= wv_q[6];
				wv_q[6] <= wv_q[5];
				wv_q[5] <= wv_q[4];
				wv_q[4] <= wv_q[3] + t1;
				wv_q[3] <= wv_q[2];
				wv_q[2] <= wv_q[1];
				wv_q[1] <= wv_q[0];
				wv_q[0] <= t1 + t2;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			rnd_q <= '0;
			widx_q <= '0;
			last_q <= 1'b0;
			for (int i = 0; i < 8; i++)
				hv_q[i] <= IV[i];
		end else begin
			case (state_q)
				C_IDLE: begin
					if (blk_valid) begin
						last_q <= blk.last;
						rnd_q <= '0;
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'(Rounds - 1))
						state_q <= C_ADD;
				end
				C_ADD: begin
					for (int i = 0; i < 8; i++)
						hv_q[i] <= hv_q[i] + wv_q[i];
					widx_q <= '0;
					state_q <= last_q ? C_OUT : C_IDLE;
				end
				C_OUT: begin
					if (out_ready) begin
						widx_q <= widx_q + 3'd1;
						if (widx_q == 3'd7) begin
							for (int i = 0; i < 8; i++)
								hv_q[i] <= IV[i];
							state_q <= C_IDLE;
						end
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ sv/sha512_message_digest_top.sv @@
// SHA-512 engine taking one message byte per item. Bytes are taken at one per cycle
// when input is not stalled; each full 128-byte block goes through a two-entry queue
// to the compression unit, which loads a block, runs 80 rounds and then adds the chaining
// value, so byte input keeps pace while the queue has room. An end of message adds
// one or two padded blocks and the digest then leaves as eight items, word 0 first.
// Input stalls after each full block until the queue takes it, while the front builds
// the padding blocks, and while a block waits for queue space.
`default_nettype none
module sha512_message_digest_top (
	input wire logic clk,
	input wire logic arst_n,
	sha_if.sink      in_ch,
	sha_if.source    out_ch
);
	import sha_pkg::*;
	logic     fv, fr, qv, qr;
	sha_blk_t fb, qb;
	sha_out_t oi;

	sha_front u_front (.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_item(sha_in_t'(in_ch.payload)), .blk_valid(fv), .blk_ready(fr), .blk(fb));
	sha_fifo u_fifo (.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fb),
		.rd_valid(qv), .rd_ready(qr), .rd_data(qb));
	sha_core u_core (.clk, .arst_n, .blk_valid(qv), .blk_ready(qr), .blk(qb),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(oi));
	assign out_ch.payload = oi;
endmodule
`default_nettype wire

@@ sv/sha_checker.sv @@
`default_nettype none
`include "sha512_message_digest_top_macros.svh"
module sha_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [67:0] out_payload
);
	`SHA_ASSERT(a_final, !out_valid || (out_payload[0] == (out_payload[3:1] == 3'd7)))
	`SHA_ASSERT_IMPL(a_next, out_valid && out_ready && !out_payload[0],
		out_valid && out_payload[3:1] == $past(out_payload[3:1]) + 3'd1)
	`SHA_ASSERT_IMPL(a_hold, out_valid && !out_ready, out_valid && $stable(out_payload))
	`SHA_ASSERT_IMPL(a_in_hold, in_valid && !in_ready, in_valid)
endmodule
bind sha512_message_digest_top sha_checker u_chk (.clk, .arst_n, .in_valid(in_ch.valid),
	.in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_payload(out_ch.payload));
`default_nettype wire

@@ verif/sha512_message_digest_top_tb.sv @@
`default_nettype none
module sha512_message_digest_top_tb;
	import sha_pkg::*;

	localparam int StallLimit = 20000;

	logic clk;
	logic arst_n;

	sha_if #(.W($bits(sha_in_t))) in_ch (.clk(clk));
	sha_if #(.W($bits(sha_out_t))) out_ch (.clk(clk));

	sha512_message_digest_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	sha_in_t pending_bytes[$];
	sha_out_t expected_words[$];
	logic [63:0] hash_state [8];
	logic [1023:0] msg_block;
	int unsigned block_fill;
	logic [60:0] byte_count;
	int errors;
	int idle_cycles;
	bit stimulus_done;
	bit quiet_mode;
	int send_gap;
	int recv_gap;
	int out_count;

	function automatic logic [63:0] rot(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	task automatic compress_block();
		logic [63:0] w [16];
		logic [63:0] v [8];
		logic [63:0] wr, s0, s1, t1, t2, x15, x2;
		for (int i = 0; i < 16; i++) w[i] = msg_block[1023 - 64 * i -: 64];
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int r = 0; r < 80; r++) begin
			if (r < 16) begin
				wr = w[r];
			end else begin
				x15 = w[(r + 1) % 16];
				x2 = w[(r + 14) % 16];
				s0 = rot(x15, 1) ^ rot(x15, 8) ^ (x15 >> 7);
				s1 = rot(x2, 19) ^ rot(x2, 61) ^ (x2 >> 6);
				wr = w[r % 16] + s0 + w[(r + 9) % 16] + s1;
				w[r % 16] = wr;
			end
			t1 = v[7] + (rot(v[4], 14) ^ rot(v[4], 18) ^ rot(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[r] + wr;
			t2 = (rot(v[0], 28) ^ rot(v[0], 34) ^ rot(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] += v[i];
	endtask

	task automatic place_byte(input int unsigned pos, input logic [7:0] b);
		msg_block[1023 - 8 * pos -: 8] = b;
	endtask

	task automatic absorb_item(input sha_in_t it);
		sha_out_t o;
		int unsigned rem;
		if (it.byte_present) begin
			place_byte(block_fill, it.data_byte);
			byte_count = byte_count + 1;
			block_fill++;
			if (block_fill == 128) begin
				compress_block();
				block_fill = 0;
			end
		end
		if (!it.end_of_message) return;
		rem = block_fill;
		place_byte(rem, 8'h80);
		for (int unsigned i = rem + 1; i < 128; i++) place_byte(i, 8'h00);
		if (rem >= 112) begin
			compress_block();
			msg_block = '0;
		end
		msg_block[127:0] = {64'h0, {byte_count, 3'b000}};
		compress_block();
		for (int i = 0; i < 8; i++) begin
			o.digest_word = hash_state[i];
			o.word_number = 3'(i);
			o.final_word = (i == 7);
			expected_words.push_back(o);
		end
		for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
		block_fill = 0;
		byte_count = '0;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic queue_message(input int len, input bit closing_byte, input int pattern);
		sha_in_t it;
		for (int i = 0; i < len; i++) begin
			it.byte_present = 1'b1;
			it.end_of_message = closing_byte && (i == len - 1);
			case (pattern)
				0: it.data_byte = 8'h00;
				1: it.data_byte = 8'hFF;
				2: it.data_byte = 8'(i);
				default: it.data_byte = 8'($urandom_range(0, 255));
			endcase
			pending_bytes.push_back(it);
			if ($urandom_range(0, 15) == 0) begin
				it.byte_present = 1'b0;
				it.end_of_message = 1'b0;
				it.data_byte = 8'($urandom_range(0, 255));
				pending_bytes.push_back(it);
			end
		end
		if (!closing_byte || len == 0) begin
			it.byte_present = 1'b0;
			it.end_of_message = 1'b1;
			it.data_byte = 8'($urandom_range(0, 255));
			pending_bytes.push_back(it);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		sha_in_t it;
		int target;
		for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
		msg_block = '0;
		block_fill = 0;
		byte_count = '0;
		errors = 0;
		stimulus_done = 1'b0;
		quiet_mode = 1'b0;
		// empty message, idle items, short fixed patterns
		it = '{data_byte: 8'hA5, byte_present: 1'b0, end_of_message: 1'b0};
		pending_bytes.push_back(it);
		queue_message(0, 1'b0, 0);
		queue_message(3, 1'b1, 2);
		queue_message(1, 1'b1, 1);
		queue_message(2, 1'b0, 0);
		// padding boundaries around the length slot and full block
		queue_message(111, 1'b1, 3);
		queue_message(112, 1'b1, 1);
		queue_message(128, 1'b1, 2);
		target = 100;
		while (target > 0) begin
			int len;
			case ($urandom_range(0, 3))
				0: len = $urandom_range(0, 8);
				1: len = $urandom_range(100, 140);
				2: len = $urandom_range(240, 260);
				default: len = $urandom_range(0, 60);
			endcase
			queue_message(len, $urandom_range(0, 1), 3);
			target -= (len + 1);
		end
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.payload <= '0;
			send_gap <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				absorb_item(sha_in_t'(in_ch.payload));
				void'(pending_bytes.pop_front());
			end
			if (in_ch.valid && !in_ch.ready) begin
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_ch.valid <= 1'b0;
			end else begin
				int unsigned avail;
				avail = pending_bytes.size();
				if (avail > 0) begin
					in_ch.payload <= pending_bytes[0];
					in_ch.valid <= 1'b1;
					if (!quiet_mode && $urandom_range(0, 9) == 0)
						send_gap <= $urandom_range(1, 8);
				end else begin
					in_ch.valid <= 1'b0;
					stimulus_done <= 1'b1;
				end
			end
			quiet_mode <= pending_bytes.size() < 100;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_gap <= 0;
			idle_cycles <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				sha_out_t got;
				sha_out_t want;
				got = sha_out_t'(out_ch.payload);
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word", got.digest_word, '0);
				end else begin
					want = expected_words.pop_front();
					if (got.digest_word !== want.digest_word)
						report_mismatch("digest_word", got.digest_word, want.digest_word);
					if (got.word_number !== want.word_number)
						report_mismatch("word_number", 64'(got.word_number),
							64'(want.word_number));
					if (got.final_word !== want.final_word)
						report_mismatch("final_word", 64'(got.final_word),
							64'(want.final_word));
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (!quiet_mode && $urandom_range(0, 7) == 0)
					recv_gap <= $urandom_range(1, 8);
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		@(posedge arst_n);
		fork
			begin
				wait (stimulus_done && expected_words.size() == 0);
				repeat (400) @(posedge clk);
			end
			begin
				wait (idle_cycles >= StallLimit);
				errors++;
			end
		join_any
		if (errors == 0)
			$display("sha512_message_digest_top verification clean");
		else
			$display("sha512_message_digest_top verification failed");
		$finish;
	end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+sv
sv/sha_pkg.sv
sv/sha_if.sv
sv/sha_front.sv
sv/sha_fifo.sv
sv/sha_core.sv
sv/sha512_message_digest_top.sv
sv/sha_checker.sv
verif/sha512_message_digest_top_tb.sv
